>>> hw/rtl/ddo_pkg.sv
// ddo_pkg: shared widths, constants, payload structs and cordic tables
// for the differential drive odometry block; no dependencies
package ddo_pkg;

  // field widths
  localparam int TICK_W   = 16;
  localparam int TRAVEL_W = 16;
  localparam int GAIN_W   = 24;
  localparam int POS_W    = 32;
  localparam int ANGLE_W  = 16;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TRAVEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd1;

  localparam logic [TRAVEL_W-1:0] TRAVEL_RESET = 16'd1001;
  localparam logic [GAIN_W-1:0]   GAIN_RESET   = 24'd179200;

  // serial multiplier operand and product widths
  localparam int MUL_W  = 34;
  localparam int PROD_W = 2 * MUL_W;

  // internal datapath widths
  localparam int MEAN_W  = 32;
  localparam int DIFF_W  = 33;
  localparam int DTH_W   = 33;
  localparam int XY_W    = 34;
  localparam int Z_W     = 32;
  localparam int DELTA_W = 34;
  localparam int QUO_W   = 33;
  localparam int U_W     = 32 + ANGLE_W;
  localparam int U_LSB   = 32 - ANGLE_W;
  localparam int SUM_W   = ((POS_W > DELTA_W) ? POS_W : DELTA_W) + 1;

  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(64'd1 << 23);
  localparam logic [MUL_W-1:0]  INV_TWO_PI = 34'd683565276;

  // cordic
  localparam int CORDIC_STEPS = 28;
  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005
  };

  typedef struct packed {
    logic signed [TICK_W-1:0] left_ticks;
    logic signed [TICK_W-1:0] right_ticks;
  } ticks_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x_out;
    logic signed [POS_W-1:0] pos_y_out;
    logic [ANGLE_W-1:0]      heading_out;
  } pose_t;

endpackage

>>> hw/rtl/ddo_mul.sv
// ddo_mul: signed shift-add multiplier, one multiplier bit per cycle
// depends on ddo_pkg
module ddo_mul (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [ddo_pkg::MUL_W-1:0]   a,
  input  logic signed [ddo_pkg::MUL_W-1:0]   b,
  output logic                               done,
  output logic signed [ddo_pkg::PROD_W-1:0]  p
);
  import ddo_pkg::*;

  localparam int CNT_W = $clog2(MUL_W + 1);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [MUL_W-1:0]   am;
  logic [MUL_W-1:0]   bm;
  logic               neg;
  logic [PROD_W-1:0]  acc;
  logic [MUL_W:0]     part;

  // add the multiplicand into the upper half when the current bit is set
  assign part = {1'b0, acc[PROD_W-1:MUL_W]} + (bm[0] ? {1'b0, am} : '0);
  assign p = $signed(acc);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(MUL_W)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath: magnitudes in, sign fixed in the last cycle
  always_ff @(posedge clk) begin
    if (start) begin
      am  <= a[MUL_W-1] ? MUL_W'(-a) : MUL_W'(a);
      bm  <= b[MUL_W-1] ? MUL_W'(-b) : MUL_W'(b);
      neg <= a[MUL_W-1] ^ b[MUL_W-1];
      acc <= '0;
      cnt <= '0;
    end else if (busy) begin
      if (cnt == CNT_W'(MUL_W)) begin
        acc <= neg ? -acc : acc;
      end else begin
        acc <= {part, acc[MUL_W-1:1]};
        bm  <= bm >> 1;
        cnt <= cnt + 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/ddo_cordic.sv
// ddo_cordic: iterative rotation cordic, one micro-rotation per cycle,
// q30 sine and cosine of a 32-bit binary angle; depends on ddo_pkg
module ddo_cordic (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [31:0]                       angle,
  output logic                              done,
  output logic signed [ddo_pkg::XY_W-1:0]   cos_q30,
  output logic signed [ddo_pkg::XY_W-1:0]   sin_q30
);
  import ddo_pkg::*;

  localparam int CNT_W = $clog2(CORDIC_STEPS);

  logic                   busy;
  logic                   fix;
  logic [CNT_W-1:0]       cnt;
  logic [1:0]             quad;
  logic signed [XY_W-1:0] x;
  logic signed [XY_W-1:0] y;
  logic signed [Z_W-1:0]  z;
  logic [31:0]            biased;
  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;

  assign biased = angle + 32'h2000_0000;
  assign xs = x >>> cnt;
  assign ys = y >>> cnt;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fix  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        fix  <= 1'b0;
      end else if (busy) begin
        if (fix) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else if (cnt == CNT_W'(CORDIC_STEPS - 1)) begin
          fix <= 1'b1;
        end
      end
    end
  end

  // rotations, then quadrant fold-back
  always_ff @(posedge clk) begin
    if (start) begin
      quad <= biased[31:30];
      z    <= $signed(angle - {biased[31:30], 30'd0});
      x    <= CORDIC_GAIN;
      y    <= '0;
      cnt  <= '0;
    end else if (busy) begin
      if (fix) begin
        case (quad)
          2'd0: begin cos_q30 <= x;  sin_q30 <= y;  end
          2'd1: begin cos_q30 <= -y; sin_q30 <= x;  end
          2'd2: begin cos_q30 <= -x; sin_q30 <= -y; end
          default: begin cos_q30 <= y; sin_q30 <= -x; end
        endcase
      end else begin
        if (!z[Z_W-1]) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - $signed(ATAN_TAB[cnt]);
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + $signed(ATAN_TAB[cnt]);
        end
        if (cnt != CNT_W'(CORDIC_STEPS - 1)) cnt <= cnt + 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/ddo_div.sv
// ddo_div: restoring divider, one quotient bit per cycle, truncates toward
// zero and clamps the quotient to +-2^31; depends on ddo_pkg
module ddo_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [ddo_pkg::U_W-1:0]    num,
  input  logic signed [ddo_pkg::DTH_W-1:0]  den,
  output logic                              done,
  output logic signed [ddo_pkg::QUO_W-1:0]  quo_out
);
  import ddo_pkg::*;

  localparam int CNT_W = $clog2(U_W);

  logic               busy;
  logic               fix;
  logic [CNT_W-1:0]   cnt;
  logic [U_W-1:0]     quo;
  logic [DTH_W-1:0]   dm;
  logic [DTH_W-1:0]   rem;
  logic               neg;
  logic [DTH_W:0]     r2;
  logic               ge;
  logic [QUO_W-1:0]   mag;

  // shift in the next dividend bit and trial-subtract
  assign r2  = {rem, quo[U_W-1]};
  assign ge  = r2 >= {1'b0, dm};
  // clamp the magnitude at 2^31
  assign mag = (|quo[U_W-1:31]) ? QUO_W'(64'd1 << 31) : QUO_W'(quo[30:0]);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fix  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        fix  <= 1'b0;
      end else if (busy) begin
        if (fix) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else if (cnt == CNT_W'(U_W - 1)) begin
          fix <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num[U_W-1] ? U_W'(-num) : U_W'(num);
      dm  <= den[DTH_W-1] ? DTH_W'(-den) : DTH_W'(den);
      neg <= num[U_W-1] ^ den[DTH_W-1];
      rem <= '0;
      cnt <= '0;
    end else if (busy) begin
      if (fix) begin
        quo_out <= neg ? $signed(-mag) : $signed(mag);
      end else begin
        rem <= ge ? DTH_W'(r2 - {1'b0, dm}) : r2[DTH_W-1:0];
        quo <= {quo[U_W-2:0], ge};
        if (cnt != CNT_W'(U_W - 1)) cnt <= cnt + 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/differential_drive_odometry.sv
// differential_drive_odometry: arc-update pose integrator, one item at a time
// the sequencer waits on the bit-serial multiplier for each product, on the cordic
// for each sine/cosine pair and on the divider for each quotient; a heading change
// that rounds to zero takes the straight path, with no second cordic run or divide
// a new item is taken only once the pose commits; an output stall delays the commit
// reset: pose and heading clear to zero, registers load their defaults
module differential_drive_odometry (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              ticks_valid,
  output logic                              ticks_ready,
  input  ddo_pkg::ticks_t                   ticks,
  output logic                              pose_valid,
  input  logic                              pose_ready,
  output ddo_pkg::pose_t                    pose,
  input  logic                              cfg_we,
  input  logic [ddo_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ddo_pkg::CFG_W-1:0]         cfg_data
);
  import ddo_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SUM      = 4'd1;
  localparam logic [3:0] S_DIF      = 4'd2;
  localparam logic [3:0] S_GAIN     = 4'd3;
  localparam logic [3:0] S_COS0     = 4'd4;
  localparam logic [3:0] S_COS1     = 4'd5;
  localparam logic [3:0] S_LINE     = 4'd6;
  localparam logic [3:0] S_ARC_MUL  = 4'd7;
  localparam logic [3:0] S_ARC_DIV  = 4'd8;
  localparam logic [3:0] S_ARC_MEAN = 4'd9;
  localparam logic [3:0] S_DONE     = 4'd10;

  localparam logic signed [SUM_W-1:0] P_HI = {{(SUM_W-POS_W+1){1'b0}}, {(POS_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] P_LO = -P_HI - 1;

  logic [3:0]                 state;
  logic                       run;
  logic                       axis;
  logic [TRAVEL_W-1:0]        travel;
  logic [GAIN_W-1:0]          gain;
  logic signed [POS_W-1:0]    pos_x;
  logic signed [POS_W-1:0]    pos_y;
  logic [ANGLE_W-1:0]         heading;
  logic [ANGLE_W-1:0]         newh;
  logic signed [TICK_W-1:0]   left;
  logic signed [TICK_W-1:0]   right;
  logic signed [MEAN_W-1:0]   mean;
  logic signed [DIFF_W-1:0]   diffv;
  logic signed [DTH_W-1:0]    dth;
  logic signed [XY_W-1:0]     c0;
  logic signed [XY_W-1:0]     s0;
  logic signed [XY_W-1:0]     c1;
  logic signed [XY_W-1:0]     s1;
  logic signed [U_W-1:0]      u;
  logic signed [QUO_W-1:0]    t;
  logic signed [DELTA_W-1:0]  dx;
  logic signed [DELTA_W-1:0]  dy;

  logic                       unit_state;
  logic                       mul_state;
  logic                       start;
  logic                       mul_done;
  logic                       cor_done;
  logic                       div_done;
  logic                       unit_done;
  logic signed [MUL_W-1:0]    mul_a;
  logic signed [MUL_W-1:0]    mul_b;
  logic signed [PROD_W-1:0]   mul_p;
  logic signed [PROD_W-1:0]   prod_rnd;
  logic [31:0]                cor_angle;
  logic signed [XY_W-1:0]     cor_c;
  logic signed [XY_W-1:0]     cor_s;
  logic signed [QUO_W-1:0]    div_q;
  logic                       pose_free;
  logic signed [SUM_W-1:0]    sum_x;
  logic signed [SUM_W-1:0]    sum_y;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
    if (v > P_HI) return P_HI[POS_W-1:0];
    else if (v < P_LO) return P_LO[POS_W-1:0];
    else return v[POS_W-1:0];
  endfunction

  assign ticks_ready = (state == S_IDLE);
  assign pose_free   = !pose_valid || pose_ready;

  // one start pulse whenever a state that runs a unit has no unit running
  assign mul_state  = (state == S_SUM) || (state == S_DIF) || (state == S_GAIN) ||
                      (state == S_LINE) || (state == S_ARC_MUL) || (state == S_ARC_MEAN);
  assign unit_state = mul_state || (state == S_COS0) || (state == S_COS1) ||
                      (state == S_ARC_DIV);
  assign start      = unit_state && !run;
  assign unit_done  = mul_done || cor_done || div_done;

  // multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_SUM: begin
        mul_a = MUL_W'(left) + MUL_W'(right);
        mul_b = $signed({{(MUL_W-TRAVEL_W){1'b0}}, travel});
      end
      S_DIF: begin
        mul_a = MUL_W'(right) - MUL_W'(left);
        mul_b = $signed({{(MUL_W-TRAVEL_W){1'b0}}, travel});
      end
      S_GAIN: begin
        mul_a = MUL_W'(diffv);
        mul_b = $signed({{(MUL_W-GAIN_W){1'b0}}, gain});
      end
      S_LINE: begin
        mul_a = MUL_W'(mean);
        mul_b = axis ? s0 : c0;
      end
      S_ARC_MUL: begin
        mul_a = axis ? (c0 - c1) : (s1 - s0);
        mul_b = $signed(INV_TWO_PI);
      end
      S_ARC_MEAN: begin
        mul_a = MUL_W'(mean);
        mul_b = MUL_W'(t);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_rnd  = mul_p + $signed(ROUND_HALF);
  assign cor_angle = (state == S_COS0) ? {heading, {U_LSB{1'b0}}} : {newh, {U_LSB{1'b0}}};
  assign sum_x     = SUM_W'(pos_x) + SUM_W'(dx);
  assign sum_y     = SUM_W'(pos_y) + SUM_W'(dy);

  ddo_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (start && mul_state),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  ddo_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (start && ((state == S_COS0) || (state == S_COS1))),
    .angle   (cor_angle),
    .done    (cor_done),
    .cos_q30 (cor_c),
    .sin_q30 (cor_s)
  );

  ddo_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (start && (state == S_ARC_DIV)),
    .num     (u),
    .den     (dth),
    .done    (div_done),
    .quo_out (div_q)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      travel <= TRAVEL_RESET;
      gain   <= GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TRAVEL: travel <= cfg_data[TRAVEL_W-1:0];
        REG_GAIN:   gain   <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and pose state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      run        <= 1'b0;
      axis       <= 1'b0;
      pos_x      <= '0;
      pos_y      <= '0;
      heading    <= '0;
    end else begin
      if (start) run <= 1'b1;
      else if (unit_done) run <= 1'b0;

      case (state)
        S_IDLE: begin
          if (ticks_valid) begin
            left  <= ticks.left_ticks;
            right <= ticks.right_ticks;
            state <= S_SUM;
          end
        end
        S_SUM: begin
          if (mul_done) begin
            mean  <= mul_p[MEAN_W:1];
            state <= S_DIF;
          end
        end
        S_DIF: begin
          if (mul_done) begin
            diffv <= mul_p[DIFF_W-1:0];
            state <= S_GAIN;
          end
        end
        S_GAIN: begin
          if (mul_done) begin
            dth   <= prod_rnd[24+DTH_W-1:24];
            state <= S_COS0;
          end
        end
        S_COS0: begin
          if (cor_done) begin
            c0   <= cor_c;
            s0   <= cor_s;
            axis <= 1'b0;
            if (dth == '0) begin
              newh  <= heading;
              state <= S_LINE;
            end else begin
              newh  <= heading + dth[ANGLE_W-1:0];
              state <= S_COS1;
            end
          end
        end
        S_COS1: begin
          if (cor_done) begin
            c1    <= cor_c;
            s1    <= cor_s;
            state <= S_ARC_MUL;
          end
        end
        // straight move along the old heading
        S_LINE: begin
          if (mul_done) begin
            if (!axis) begin
              dx   <= mul_p[30+DELTA_W-1:30];
              axis <= 1'b1;
            end else begin
              dy    <= mul_p[30+DELTA_W-1:30];
              state <= S_DONE;
            end
          end
        end
        // arc: scale the sine/cosine difference to radians
        S_ARC_MUL: begin
          if (mul_done) begin
            u     <= mul_p[U_LSB+U_W-1:U_LSB];
            state <= S_ARC_DIV;
          end
        end
        S_ARC_DIV: begin
          if (div_done) begin
            t     <= div_q;
            state <= S_ARC_MEAN;
          end
        end
        S_ARC_MEAN: begin
          if (mul_done) begin
            if (!axis) begin
              dx    <= mul_p[30+DELTA_W-1:30];
              axis  <= 1'b1;
              state <= S_ARC_MUL;
            end else begin
              dy    <= mul_p[30+DELTA_W-1:30];
              state <= S_DONE;
            end
          end
        end
        // commit the pose once the output register is free
        S_DONE: begin
          if (pose_free) begin
            pos_x      <= sat_pos(sum_x);
            pos_y      <= sat_pos(sum_y);
            heading    <= newh;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      pose_valid <= 1'b0;
    end else if (state == S_DONE && pose_free) begin
      pose_valid <= 1'b1;
    end else if (pose_ready) begin
      pose_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (state == S_DONE && pose_free) begin
      pose.pos_x_out   <= sat_pos(sum_x);
      pose.pos_y_out   <= sat_pos(sum_y);
      pose.heading_out <= newh;
    end
  end

  // only one unit finishes at a time
  a_one_done: assert property (@(posedge clk) disable iff (rst)
    $onehot0({mul_done, cor_done, div_done}))
    else $error("more than one arithmetic unit finished at once");

  // a unit finishes only after it was started
  a_done_run: assert property (@(posedge clk) disable iff (rst)
    unit_done |-> run)
    else $error("unit finished without a pending start");

  // heading moves only at the commit
  a_heading_commit: assert property (@(posedge clk) disable iff (rst)
    (state != S_DONE) |=> $stable(heading))
    else $error("heading changed outside the commit");

  // a straight move keeps the heading
  a_line_heading: assert property (@(posedge clk) disable iff (rst)
    (state == S_LINE) |-> (newh == heading))
    else $error("straight move with a changed heading");

endmodule

>>> tb/sv/tb_differential_drive_odometry.sv
// tb_differential_drive_odometry: self-checking testbench for the odometry block
// drives tick items and register writes, predicts each pose and compares it
// depends on ddo_pkg and differential_drive_odometry
module tb_differential_drive_odometry;
  timeunit 1ns;
  timeprecision 1ps;
  import ddo_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 500;
  localparam int HOLDOFF_CYCLES = 1500;
  localparam longint INV_TWO_PI_Q32 = 683565276;

  // pose predictor and store of expected poses
  class pose_scoreboard;
    longint travel, gain;
    longint x, y;
    logic [ANGLE_W-1:0] hdg;
    pose_t pending_poses[$];
    int mismatches, checked, arcs, straights, saturations;

    function new();
      travel = TRAVEL_RESET;
      gain = GAIN_RESET;
      x = 0;
      y = 0;
      hdg = '0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == REG_TRAVEL) travel = data[TRAVEL_W-1:0];
      else if (idx == REG_GAIN) gain = data[GAIN_W-1:0];
    endfunction

    // q30 cosine and sine of a 32-bit binary angle
    function void sin_cos(input logic [31:0] ang, output longint c, output longint s);
      logic [31:0] shifted, zr;
      logic [1:0] quad;
      longint z, cx, cy, nx;
      shifted = ang + 32'h2000_0000;
      quad = shifted[31:30];
      zr = ang - {quad, 30'd0};
      z = longint'($signed(zr));
      cx = CORDIC_GAIN;
      cy = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        if (z >= 0) begin
          nx = cx - (cy >>> i);
          cy = cy + (cx >>> i);
          z -= longint'(ATAN_TAB[i]);
        end else begin
          nx = cx + (cy >>> i);
          cy = cy - (cx >>> i);
          z += longint'(ATAN_TAB[i]);
        end
        cx = nx;
      end
      case (quad)
        2'd0: begin c = cx; s = cy; end
        2'd1: begin c = -cy; s = cx; end
        2'd2: begin c = -cx; s = -cy; end
        default: begin c = cy; s = -cx; end
      endcase
    endfunction

    function longint arc_step(longint mean, longint sdiff, longint dth);
      longint u, t;
      u = (sdiff * INV_TWO_PI_Q32) >>> (32 - ANGLE_W);
      t = u / dth;
      if (t > (64'sd1 <<< 31)) t = 64'sd1 <<< 31;
      if (t < -(64'sd1 <<< 31)) t = -(64'sd1 <<< 31);
      return (mean * t) >>> 30;
    endfunction

    function longint clamp_pos(longint v);
      longint hi, lo;
      hi = (64'sd1 <<< (POS_W - 1)) - 1;
      lo = -hi - 1;
      if (v > hi || v < lo) saturations++;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    // note an accepted tick item and queue the pose it produces
    function void note_ticks(ticks_t t);
      longint tl, tr, mean, dth, c0, s0, c1, s1, dx, dy;
      logic [ANGLE_W-1:0] nh;
      pose_t p;
      tl = longint'(t.left_ticks) * travel;
      tr = longint'(t.right_ticks) * travel;
      mean = (tl + tr) >>> 1;
      dth = ((tr - tl) * gain + (64'sd1 <<< 23)) >>> 24;
      sin_cos({hdg, {(32 - ANGLE_W){1'b0}}}, c0, s0);
      if (dth != 0) begin
        nh = hdg + dth[ANGLE_W-1:0];
        sin_cos({nh, {(32 - ANGLE_W){1'b0}}}, c1, s1);
        dx = arc_step(mean, s1 - s0, dth);
        dy = arc_step(mean, c0 - c1, dth);
        arcs++;
      end else begin
        nh = hdg;
        dx = (mean * c0) >>> 30;
        dy = (mean * s0) >>> 30;
        straights++;
      end
      x = clamp_pos(x + dx);
      y = clamp_pos(y + dy);
      hdg = nh;
      p.pos_x_out = x[POS_W-1:0];
      p.pos_y_out = y[POS_W-1:0];
      p.heading_out = hdg;
      pending_poses.push_back(p);
    endfunction

    // compare an accepted pose with the oldest expectation
    function void check_pose(pose_t got);
      pose_t exp_p;
      if (pending_poses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pose item x=%0d y=%0d h=%0d",
          got.pos_x_out, got.pos_y_out, got.heading_out);
        return;
      end
      exp_p = pending_poses.pop_front();
      checked++;
      if (got.pos_x_out !== exp_p.pos_x_out || got.pos_y_out !== exp_p.pos_y_out ||
          got.heading_out !== exp_p.heading_out) begin
        mismatches++;
        if (mismatches <= 10)
          $display("pose %0d mismatch: x %0d/%0d y %0d/%0d h %0d/%0d (exp/got)", checked,
            exp_p.pos_x_out, got.pos_x_out, exp_p.pos_y_out, got.pos_y_out,
            exp_p.heading_out, got.heading_out);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic ticks_valid = 1'b0;
  logic ticks_ready;
  ticks_t ticks = '0;
  logic pose_valid;
  logic pose_ready = 1'b0;
  pose_t pose;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_TRAVEL;
  logic [CFG_W-1:0] cfg_data = '0;

  pose_scoreboard sb = new();
  int idle_cycles = 0;
  int holdoff_req = 0;
  int sent = 0;

  always #2 clk = ~clk;

  differential_drive_odometry u_top (
    .clk(clk), .rst(rst),
    .ticks_valid(ticks_valid), .ticks_ready(ticks_ready), .ticks(ticks),
    .pose_valid(pose_valid), .pose_ready(pose_ready), .pose(pose),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // handshakes are sampled mid-cycle; inputs and outputs only move at the rising edge
  always @(negedge clk) begin
    if (!rst) begin
      if (ticks_valid && ticks_ready) sb.note_ticks(ticks);
      if (pose_valid && pose_ready) sb.check_pose(pose);
      if ((ticks_valid && ticks_ready) || (pose_valid && pose_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
        $display("tb_differential_drive_odometry failed");
        $finish;
      end
    end
  end

  // receiver stall pattern, with a long hold-off on request
  int rx_cycle = 0;
  int rx_hold = 0;
  always @(posedge clk) begin
    rx_cycle++;
    if (holdoff_req > 0) begin
      rx_hold = holdoff_req;
      holdoff_req = 0;
    end
    if (rx_hold > 0) begin
      rx_hold--;
      pose_ready <= 1'b0;
    end else begin
      case ((rx_cycle / 300) % 4)
        0: pose_ready <= 1'b1;
        1: pose_ready <= ($urandom_range(0, 1) == 1);
        2: pose_ready <= ($urandom_range(0, 3) == 0);
        default: pose_ready <= (rx_cycle % 7) < 5;
      endcase
    end
  end

  // offer one item and hold it until accepted
  task automatic send_ticks(input logic signed [TICK_W-1:0] l, r);
    ticks_t t;
    t.left_ticks = l;
    t.right_ticks = r;
    ticks <= t;
    ticks_valid <= 1'b1;
    do @(negedge clk); while (!ticks_ready);
    @(posedge clk);
    sent++;
  endtask

  task automatic pause_sender(input int n);
    ticks_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    ticks_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_poses.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  // random tick pair: half small motion, some full range, some edge values, some spins
  task automatic send_random();
    logic signed [TICK_W-1:0] l, r;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        l = $signed(16'($urandom_range(0, 200))) - 16'sd100;
        r = l + $signed(16'($urandom_range(0, 20))) - 16'sd10;
      end
      4: begin
        l = $signed(16'($urandom_range(0, 100))) - 16'sd50;
        r = l;
      end
      5, 6: begin
        l = 16'($urandom);
        r = 16'($urandom);
      end
      7: begin
        l = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        r = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      end
      default: begin
        l = 16'($urandom);
        r = -l;
      end
    endcase
    send_ticks(l, r);
  endtask

  task automatic random_burst(input int n);
    int left_n, burst;
    left_n = n;
    while (left_n > 0) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst && left_n > 0; i++) begin
        send_random();
        left_n--;
      end
      case ($urandom_range(0, 9))
        0, 1, 2: ;
        9: wait_drained();
        default: pause_sender($urandom_range(1, 40));
      endcase
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, straight, spin, tiny turns, wraps
    send_ticks(16'sd0, 16'sd0);
    send_ticks(16'sd100, 16'sd100);
    send_ticks(16'sh7FFF, 16'sh7FFF);
    send_ticks(16'sh8000, 16'sh8000);
    send_ticks(16'sh7FFF, 16'sh8000);
    send_ticks(16'sh8000, 16'sh7FFF);
    send_ticks(16'sd0, 16'sd1);
    send_ticks(16'sd1, 16'sd0);
    send_ticks(-16'sd1, -16'sd1);
    send_ticks(16'sh7FFF, 16'sd0);
    send_ticks(16'sd0, 16'sh8000);
    send_ticks(16'shFFFF, 16'sh0000);
    send_ticks(16'sh5555, 16'shAAAA);
    send_ticks(16'shAAAA, 16'sh5555);
    for (int i = 0; i < 6; i++) send_ticks(16'sh8000, 16'sh7FFF);
    send_ticks(16'sd50, 16'sd60);

    // defaults, then pressure: receiver holds off while items keep coming
    random_burst(150);
    wait_drained();
    holdoff_req = HOLDOFF_CYCLES;
    for (int i = 0; i < 20; i++) send_random();
    random_burst(50);

    // register settings, extremes included
    write_reg(REG_TRAVEL, 24'hFF_FFFF);
    write_reg(REG_GAIN, 24'hFF_FFFF);
    for (int i = 0; i < 20; i++) send_ticks(16'sh7FFF, 16'sh7FFF);
    send_ticks(16'sh8000, 16'sh8000);
    random_burst(200);

    write_reg(REG_GAIN, 24'd0);
    random_burst(200);

    write_reg(REG_TRAVEL, 24'd0);
    write_reg(REG_GAIN, 24'($urandom));
    random_burst(150);

    write_reg(REG_TRAVEL, 24'd1);
    write_reg(REG_GAIN, 24'd1);
    random_burst(150);

    // unused indexes must leave the registers alone
    write_reg(REG_SPARE_LO, 24'($urandom));
    write_reg(REG_SPARE_HI, 24'($urandom));
    write_reg(REG_TRAVEL, 24'($urandom));
    write_reg(REG_GAIN, 24'($urandom_range(100000, 300000)));
    random_burst(300);

    write_reg(REG_TRAVEL, 24'(TRAVEL_RESET));
    write_reg(REG_GAIN, 24'(GAIN_RESET));
    random_burst(550);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d tick items: %0d arc and %0d straight updates, %0d saturations",
      sent, sb.arcs, sb.straights, sb.saturations);
    $display("checked %0d poses, %0d mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_poses.size() == 0) begin
      $display("tb_differential_drive_odometry passed");
    end else begin
      $display("tb_differential_drive_odometry failed");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/ddo_pkg.sv
hw/rtl/ddo_mul.sv
hw/rtl/ddo_cordic.sv
hw/rtl/ddo_div.sv
hw/rtl/differential_drive_odometry.sv
tb/sv/tb_differential_drive_odometry.sv
